// ===== hw/rtl/u8u16_pkg.sv =====
// Shared types, constants and unit-forming functions for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int unsigned MAX_UNITS = 4;    // most units one input byte can cause
  localparam int unsigned CNT_W     = 3;    // holds 0..MAX_UNITS
  localparam int unsigned IDX_W     = 2;    // indexes MAX_UNITS slots

  localparam logic [15:0] SUBST_UNIT = 16'hFFFD;
  localparam logic [15:0] HI_BASE    = 16'hD800;
  localparam logic [15:0] LO_BASE    = 16'hDC00;
  localparam logic [10:0] PLANE1_OFS = 11'h040;   // 0x10000 >> 10
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;

  typedef logic [15:0] unit_t;
  typedef logic [MAX_UNITS-1:0][15:0] unit_vec_t;

  // Sequence assembly state
  typedef struct packed {
    logic [20:0] acc;
    logic [1:0]  needed;
    logic [1:0]  buffered;
  } dec_state_t;

  // Units produced by one code point
  typedef struct packed {
    logic [1:0] n;
    unit_t      u0;
    unit_t      u1;
  } char_out_t;

  // Everything one input byte produces
  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic [MAX_UNITS-1:0] last;
    unit_vec_t            units;
  } dec_result_t;

  function automatic unit_t order_unit(input unit_t u, input logic swap);
    order_unit = swap ? {u[7:0], u[15:8]} : u;
  endfunction

  // One code point to one unit or a surrogate pair; bad values become the substitute.
  function automatic char_out_t put_char(input logic [20:0] cp, input logic swap);
    logic [20:0] v;
    logic [10:0] hi_ofs;
    char_out_t   r;
    v = cp;
    if (cp > CP_MAX || (cp inside {[21'h00D800:21'h00DFFF]})) begin
      v = {5'd0, SUBST_UNIT};
    end
    hi_ofs = v[20:10] - PLANE1_OFS;
    if (v[20:16] != 5'd0) begin
      r.n  = 2'd2;
      r.u0 = order_unit(HI_BASE | {6'd0, hi_ofs[9:0]}, swap);
      r.u1 = order_unit(LO_BASE | {6'd0, v[9:0]}, swap);
    end else begin
      r.n  = 2'd1;
      r.u0 = order_unit(v[15:0], swap);
      r.u1 = r.u0;
    end
    put_char = r;
  endfunction

endpackage

// ===== hw/rtl/u8u16_decode.sv =====
// Byte decoder: next sequence state and the list of units one byte produces.
`timescale 1ns / 1ps

module u8u16_decode (
  input  logic [7:0]             in_byte,
  input  logic                   swap,
  input  u8u16_pkg::dec_state_t  st,
  output u8u16_pkg::dec_state_t  st_nxt,
  output u8u16_pkg::dec_result_t res
);
  import u8u16_pkg::*;

  logic        pending;
  logic        is_cont;
  logic [20:0] acc_sh;
  logic [1:0]  flush_n;
  char_out_t   tail;
  logic        tail_last;
  unit_t       subst;

  assign pending = (st.needed != 2'd0);
  assign is_cont = (in_byte[7:6] == 2'b10);
  assign acc_sh  = {st.acc[14:0], in_byte[5:0]};
  assign subst   = order_unit(SUBST_UNIT, swap);

  always_comb begin
    st_nxt    = st;
    flush_n   = 2'd0;
    tail      = '0;
    tail_last = 1'b0;
    if (pending && is_cont) begin
      if (st.needed == 2'd1) begin
        tail   = put_char(acc_sh, swap);
        st_nxt = '0;
      end else begin
        st_nxt.acc      = acc_sh;
        st_nxt.needed   = st.needed - 2'd1;
        st_nxt.buffered = st.buffered + 2'd1;
      end
    end else begin
      // broken sequence: one substitute per buffered byte, then treat as lead
      if (pending) begin
        flush_n = st.buffered;
      end
      st_nxt = '0;
      if (in_byte == 8'h00) begin
        tail.n    = 2'd1;
        tail.u0   = '0;
        tail.u1   = '0;
        tail_last = 1'b1;
      end else if (!in_byte[7]) begin
        tail = put_char({13'd0, in_byte}, swap);
      end else if (in_byte[7:5] == 3'b110) begin
        st_nxt.acc      = {16'd0, in_byte[4:0]};
        st_nxt.needed   = 2'd1;
        st_nxt.buffered = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        st_nxt.acc      = {17'd0, in_byte[3:0]};
        st_nxt.needed   = 2'd2;
        st_nxt.buffered = 2'd1;
      end else if (in_byte[7:3] == 5'b11110) begin
        st_nxt.acc      = {18'd0, in_byte[2:0]};
        st_nxt.needed   = 2'd3;
        st_nxt.buffered = 2'd1;
      end else begin
        tail = put_char({5'd0, SUBST_UNIT}, swap);   // stray continuation or 0xF8-0xFF
      end
    end
  end

  // substitutes first, then the byte's own units
  always_comb begin
    res.count = {1'b0, flush_n} + {1'b0, tail.n};
    for (int k = 0; k < MAX_UNITS; k++) begin
      if (k < flush_n) begin
        res.units[k] = subst;
        res.last[k]  = 1'b0;
      end else if (k == flush_n) begin
        res.units[k] = tail.u0;
        res.last[k]  = tail_last;
      end else begin
        res.units[k] = tail.u1;
        res.last[k]  = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per item and delivers UTF-16 code units, one per output
// item. Each accepted byte is decoded in the same cycle and all units it causes
// (none up to four: substitutes for a broken sequence, a unit, a surrogate pair,
// or the terminator) are written into a four-slot result register, which then
// drains one unit per cycle while out_stall is low. A byte is taken whenever that
// register will be empty at the next edge, so a byte that yields several units
// (a surrogate pair, substitutes) holds off the next byte until all have left;
// with no output stall, plain text and most characters stream at one byte per
// cycle. A zero byte flushes any pending sequence and yields unit 0 with
// out_last high; it is never byte-swapped. cfg_wdata selects byte-swapped output
// when written with cfg_we high; write it only while no units are outstanding.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_unit,
  output logic        out_last
);
  import u8u16_pkg::*;

  logic                 swap_r;
  dec_state_t           st_r, st_nxt;
  dec_result_t          res;
  unit_vec_t            units_r;
  logic [MAX_UNITS-1:0] last_r;
  logic [CNT_W-1:0]     cnt_r;     // units still to deliver
  logic [IDX_W-1:0]     idx_r;     // slot of the unit on the output
  logic                 in_acc;
  logic                 out_acc;

  u8u16_decode u_decode (
    .in_byte (in_byte),
    .swap    (swap_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;
  // free next edge: nothing queued, or the last queued unit leaves now
  assign in_stall  = (cnt_r > CNT_W'(1)) || ((cnt_r == CNT_W'(1)) && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign out_unit = units_r[idx_r];
  assign out_last = last_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
      st_r   <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        swap_r <= cfg_wdata;
      end
      if (in_acc) begin
        st_r  <= st_nxt;
        cnt_r <= res.count;
        idx_r <= '0;
      end else if (out_acc) begin
        cnt_r <= cnt_r - CNT_W'(1);
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // unit slots: payload only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      units_r <= res.units;
      last_r  <= res.last;
    end
  end

endmodule

// ===== hw/rtl/u8u16_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to the top level.
`timescale 1ns / 1ps

module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_unit,
  input logic        out_last
);

  // reset empties the result slots
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled unit holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_unit) && $stable(out_last))
    else $error("stalled output changed");

  // the terminator is the zero unit, never swapped
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_unit == 16'h0000)
    else $error("last item with nonzero unit");

  // a zero byte always yields at least its terminator
  a_term_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_byte == 8'h00 |=> out_valid)
    else $error("zero byte gave no output");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_byte   (in_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_unit  (out_unit),
  .out_last  (out_last)
);

// ===== test/utf8_to_utf16_transcoder_tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 transcoder: byte stream in, code units out.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_tb;

  localparam logic [15:0] REPLACEMENT = u8u16_pkg::SUBST_UNIT;

  // One UTF-16 code unit as it should leave the block
  typedef struct {
    logic [15:0] unit;
    logic        last;
  } utf16_unit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_unit;
  logic        out_last;

  utf8_to_utf16_transcoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_unit  (out_unit),
    .out_last  (out_last)
  );

  // Bytes waiting to be sent, and units the decoder still owes us
  logic [7:0]  text_bytes[$];
  utf16_unit_t units_due[$];

  // Shadow of the decoder: swap setting plus the partial sequence being assembled
  logic        swap_mode = 1'b0;
  logic [20:0] partial_cp = '0;
  logic [1:0]  conts_left = '0;
  logic [1:0]  held_bytes = '0;

  // Gap / stall shaping; steady_flow turns off idling on both sides
  logic        steady_flow = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;

  int          mismatches = 0;
  int          bytes_sent = 0;
  int          units_checked = 0;
  int          terminators = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic logic [15:0] ordered(input logic [15:0] u);
    return swap_mode ? {u[7:0], u[15:8]} : u;
  endfunction

  task automatic owe_unit(input logic [15:0] u, input logic last);
    utf16_unit_t e;
    e.unit = u;
    e.last = last;
    units_due.push_back(e);
  endtask

  // Code point -> one unit or a surrogate pair; out-of-range and surrogate
  // values collapse to the replacement character.
  task automatic owe_code_point(input logic [20:0] cp);
    logic [20:0] ofs;
    if (cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF))
      cp = {5'd0, REPLACEMENT};
    if (cp[20:16] != 5'd0) begin
      ofs = cp - 21'h010000;
      owe_unit(ordered(16'hD800 | {6'd0, ofs[19:10]}), 1'b0);
      owe_unit(ordered(16'hDC00 | {6'd0, ofs[9:0]}), 1'b0);
    end else begin
      owe_unit(ordered(cp[15:0]), 1'b0);
    end
  endtask

  // Advance the shadow decoder by one accepted byte and queue what it yields
  task automatic decode_byte(input logic [7:0] b);
    logic [20:0] cp;
    int i;
    if (conts_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        cp = {partial_cp[14:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          held_bytes = '0;
          partial_cp = '0;
          owe_code_point(cp);
        end else begin
          partial_cp = cp;
          held_bytes = held_bytes + 2'd1;
        end
        return;
      end
      // Sequence broken: one replacement per byte held, then treat b as a lead
      for (i = 0; i < held_bytes; i++)
        owe_code_point({5'd0, REPLACEMENT});
      conts_left = '0;
      held_bytes = '0;
      partial_cp = '0;
    end
    if (b == 8'h00) begin
      owe_unit(16'h0000, 1'b1);   // terminator is never swapped
    end else if (b[7] == 1'b0) begin
      owe_code_point({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      partial_cp = {16'd0, b[4:0]};
      conts_left = 2'd1;
      held_bytes = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      partial_cp = {17'd0, b[3:0]};
      conts_left = 2'd2;
      held_bytes = 2'd1;
    end else if (b[7:3] == 5'b11110) begin
      partial_cp = {18'd0, b[2:0]};
      conts_left = 2'd3;
      held_bytes = 2'd1;
    end else begin
      // stray continuation or 0xF8-0xFF
      owe_code_point({5'd0, REPLACEMENT});
    end
  endtask

  // Byte driver: predicts on accept, then holds, idles or launches the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        bytes_sent++;
      end
      if (in_valid && in_stall) begin
        // stalled: payload stays put
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (text_bytes.size() != 0) begin
        in_byte  <= text_bytes.pop_front();
        in_valid <= 1'b1;
        send_gap = steady_flow ? 0 : gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Unit monitor: checks each accepted unit against the oldest one owed, then picks stall
  always @(posedge clk) begin
    utf16_unit_t e;
    if (rst_n && out_valid && !out_stall) begin
      units_checked++;
      if (out_last) terminators++;
      if (units_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected unit %h last %b, nothing owed", out_unit, out_last);
      end else begin
        e = units_due.pop_front();
        if (out_unit !== e.unit || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unit mismatch: expected %h last %b, got %h last %b",
                     e.unit, e.last, out_unit, out_last);
        end
      end
    end
    if (!rst_n || steady_flow) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) stall_left = gap_len();
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One random character, mostly well formed; some truncated sequences and raw noise
  task automatic queue_random_char();
    int k;
    int n_cont;
    int i;
    logic [7:0] lead;
    k = $urandom_range(0, 99);
    n_cont = 0;
    if (k < 35) begin
      text_bytes.push_back(8'($urandom_range(1, 127)));
      return;
    end else if (k < 82) begin
      if (k < 50) begin
        lead = 8'($urandom_range(8'hC0, 8'hDF));
        n_cont = 1;
      end else if (k < 66) begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));   // ED lands on surrogates
        n_cont = 2;
      end else begin
        // F0-F4 mostly valid planes; F5-F7 overshoot 0x10FFFF
        lead = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hF5, 8'hF7))
                                           : 8'($urandom_range(8'hF0, 8'hF4));
        n_cont = 3;
      end
    end else if (k < 87) begin
      text_bytes.push_back(8'h00);
      return;
    end else if (k < 94) begin
      // truncated: the next character breaks it
      n_cont = $urandom_range(1, 3);
      lead = (n_cont == 1) ? 8'hC5 : (n_cont == 2) ? 8'hE3 : 8'hF1;
      n_cont = $urandom_range(0, n_cont - 1);
    end else begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    text_bytes.push_back(lead);
    for (i = 0; i < n_cont; i++)
      text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  task automatic queue_random_text(input int n_bytes);
    int target;
    target = text_bytes.size() + n_bytes;
    while (text_bytes.size() < target) queue_random_char();
  endtask

  // Register write while the block is idle; the shadow follows at once
  task automatic set_swap(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    swap_mode = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every byte is in and every owed unit is out, plus a short margin
  task automatic wait_drained();
    @(negedge clk);
    while (text_bytes.size() != 0 || in_valid || units_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Directed text: ASCII extremes, 2/3/4-byte forms, top code point, overshoot,
  // encoded surrogate, stray continuation, bad lead, and two broken sequences
  // (the second cut short by a terminator, giving four units from one byte).
  logic [7:0] directed_text [27] = '{
    8'h00, 8'h7F,
    8'hC3, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hED, 8'hBF, 8'hBF,
    8'hBF,
    8'hFF,
    8'hE2, 8'h82, 8'h41,
    8'hF0, 8'h9F, 8'h98, 8'h00
  };

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_swap(1'b0);
    foreach (directed_text[i]) text_bytes.push_back(directed_text[i]);
    wait_drained();

    set_swap(1'b1);
    queue_random_text(25);
    wait_drained();

    set_swap(1'b0);
    queue_random_text(25);
    wait_drained();

    // back-to-back on both sides with swapping on
    set_swap(1'b1);
    steady_flow = 1'b1;
    queue_random_text(25);
    wait_drained();
    steady_flow = 1'b0;
    repeat (10) @(posedge clk);

    $display("run covered %0d bytes in, %0d units checked (%0d terminators),",
             bytes_sent, units_checked, terminators);
    $display("native and swapped order, with and without idling on both sides");
    if (mismatches == 0 && units_due.size() == 0) begin
      $display("utf8_to_utf16_transcoder_tb: clean");
    end else begin
      $display("utf8_to_utf16_transcoder_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d bytes unsent and %0d units owed",
             text_bytes.size(), units_due.size());
    $display("utf8_to_utf16_transcoder_tb: errors");
    $finish;
  end

endmodule
